// ===== rtl/core/ipv4rx_pkg.sv =====
// Package for the IPv4 receive check: payload structs, verdict and class codes.
// No dependencies.
package ipv4rx_pkg;

  localparam int ERROR_COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    V_ACCEPT   = 4'd0,
    V_SHORT    = 4'd1,
    V_VERSION  = 4'd2,
    V_HDRLEN   = 4'd3,
    V_TOTLEN   = 4'd4,
    V_HDRSUM   = 4'd5,
    V_FRAGMENT = 4'd6,
    V_NOTOURS  = 4'd7,
    V_L4SUM    = 4'd8
  } verdict_t;

  typedef enum logic [2:0] {
    PC_ICMP  = 3'd0,
    PC_UDP   = 3'd1,
    PC_TCP   = 3'd2,
    PC_GRE   = 3'd3,
    PC_OTHER = 3'd4
  } pclass_t;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_GRE  = 8'd47;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       checksum_trusted;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [2:0]  protocol_class;
    logic [31:0] source_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
    logic [31:0] l4_error_count;
  } out_word_t;

  // Frame summary handed from front (parser) to back (checker).
  typedef struct packed {
    logic [15:0] size_m1;       // index of last byte (saturated)
    logic [7:0]  ver_len;
    logic [15:0] total_length;
    logic [15:0] fragment_word;
    logic [7:0]  protocol;
    logic [31:0] source_word;
    logic [31:0] dest_word;
    logic [16:0] header_fold;   // partially folded sums
    logic [16:0] payload_fold;
    logic        udp_zero;
    logic        trusted;
  } frame_sum_t;

  function automatic logic [15:0] fold17(input logic [16:0] s);
    logic [16:0] t;
    t = {16'd0, s[16]} + {1'b0, s[15:0]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// ===== rtl/core/ipv4_rx_header_and_l4_checksum_check.sv =====
// IPv4 receive header check with TCP/UDP checksum verification.
// Takes one frame byte per cycle, back to back; stall only when the
// summary queue fills behind a stalled result. The result word follows the
// last byte through the summary register (loaded on the edge that takes it),
// then the queue, the check stage and the output register.
// Synchronous active-high rst clears parser state, queue, error counter
// and local_address.
module ipv4_rx_header_and_l4_checksum_check #(
  parameter int ERROR_COUNT_WIDTH = ipv4rx_pkg::ERROR_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ipv4rx_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ipv4rx_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);
  import ipv4rx_pkg::*;

  logic [31:0] local_address;
  logic        sum_valid, room, q_ne, q_pop;
  frame_sum_t  sum, head;

  // Config register: always writable.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) local_address <= '0;
    else if (cfg_valid) local_address <= cfg_data;
  end

  // Parser (front) -> queue -> checker (back).
  ipv4rx_front u_front (
    .clk, .rst,
    .valid     (in_valid),
    .stall     (in_stall),
    .in_word   (in_word),
    .sum_valid (sum_valid),
    .sum_ready (room),
    .sum       (sum)
  );

  ipv4rx_queue u_queue (
    .clk, .rst,
    .push      (sum_valid),
    .push_data (sum),
    .has_room  (room),
    .not_empty (q_ne),
    .pop       (q_pop),
    .head      (head)
  );

  ipv4rx_back #(.ERROR_COUNT_WIDTH(ERROR_COUNT_WIDTH)) u_back (
    .clk, .rst,
    .local_address (local_address),
    .head_valid    (q_ne),
    .head_pop      (q_pop),
    .head          (head),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );
endmodule

// ===== rtl/core/ipv4rx_front.sv =====
// Front end: per-byte parser, field capture and running ones'-complement sums.
// Depends on ipv4rx_pkg.
module ipv4rx_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid,
  output logic                   stall,
  input  ipv4rx_pkg::in_word_t   in_word,
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output ipv4rx_pkg::frame_sum_t sum
);
  import ipv4rx_pkg::*;

  logic [15:0] byte_index;
  logic [16:0] header_sum;   // kept folded to 17 bits
  logic [16:0] payload_sum;
  logic [7:0]  ver_len;
  logic [15:0] total_length;
  logic [15:0] fragment_word;
  logic [7:0]  protocol;
  logic [31:0] source_word;
  logic [31:0] dest_word;
  logic        udp_zero;
  logic        trusted;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  vl_eff;
  logic [5:0]  ihl;
  logic [15:0] off;
  logic [15:0] word16;
  logic        in_hdr, in_pay;
  logic [16:0] hs_next, ps_next;
  logic [15:0] tl_eff;
  logic [31:0] src_eff, dst_eff;
  logic [15:0] frag_eff;
  logic [7:0]  prot_eff;
  logic        uz_eff, tr_eff;

  assign stall = !sum_ready;
  assign take  = valid && sum_ready;
  assign b     = in_word.data_byte;

  always_comb begin
    vl_eff   = (byte_index == 16'd0) ? b : ver_len;
    tr_eff   = (byte_index == 16'd0) ? in_word.checksum_trusted : trusted;
    tl_eff   = total_length;
    frag_eff = fragment_word;
    prot_eff = protocol;
    src_eff  = source_word;
    dst_eff  = dest_word;
    case (byte_index)
      16'd2:   tl_eff[15:8]  = b;
      16'd3:   tl_eff[7:0]   = b;
      16'd6:   frag_eff[15:8] = b;
      16'd7:   frag_eff[7:0]  = b;
      16'd9:   prot_eff = b;
      16'd12:  src_eff[31:24] = b;
      16'd13:  src_eff[23:16] = b;
      16'd14:  src_eff[15:8]  = b;
      16'd15:  src_eff[7:0]   = b;
      16'd16:  dst_eff[31:24] = b;
      16'd17:  dst_eff[23:16] = b;
      16'd18:  dst_eff[15:8]  = b;
      16'd19:  dst_eff[7:0]   = b;
      default: ;
    endcase
    ihl    = {vl_eff[3:0], 2'b00};
    off    = byte_index - {10'd0, ihl};
    in_hdr = byte_index < {10'd0, ihl};
    in_pay = !in_hdr && (byte_index >= 16'd20) && (byte_index < total_length)
             && (byte_index != 16'hffff);
    word16  = byte_index[0] ? {8'd0, b} : {b, 8'd0};
    hs_next = header_sum;
    if (in_hdr) hs_next = {1'b0, fold17(header_sum)} + {1'b0, word16};
    ps_next = payload_sum;
    uz_eff  = udp_zero;
    if (in_pay) begin
      ps_next = {1'b0, fold17(payload_sum)} +
                {1'b0, (off[0] ? {8'd0, b} : {b, 8'd0})};
      if ((off == 16'd6 || off == 16'd7) && b != 8'd0) uz_eff = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0; header_sum <= '0; payload_sum <= '0; ver_len <= '0;
      total_length <= '0; fragment_word <= '0; protocol <= '0;
      source_word <= '0; dest_word <= '0; udp_zero <= 1'b1; trusted <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= take && in_word.last_byte;
      if (take) begin
        if (in_word.last_byte) begin
          byte_index <= '0; header_sum <= '0; payload_sum <= '0; ver_len <= '0;
          total_length <= '0; fragment_word <= '0; protocol <= '0;
          source_word <= '0; dest_word <= '0; udp_zero <= 1'b1; trusted <= 1'b0;
        end else begin
          if (byte_index != 16'hffff) byte_index <= byte_index + 16'd1;
          header_sum <= hs_next; payload_sum <= ps_next; ver_len <= vl_eff;
          total_length <= tl_eff; fragment_word <= frag_eff; protocol <= prot_eff;
          source_word <= src_eff; dest_word <= dst_eff; udp_zero <= uz_eff;
          trusted <= tr_eff;
        end
      end
    end
  end

  // Summary register; loaded only on the last byte.
  always_ff @(posedge clk) begin
    if (take && in_word.last_byte) begin
      sum.size_m1       <= byte_index;
      sum.ver_len       <= vl_eff;
      sum.total_length  <= tl_eff;
      sum.fragment_word <= frag_eff;
      sum.protocol      <= prot_eff;
      sum.source_word   <= src_eff;
      sum.dest_word     <= dst_eff;
      sum.header_fold   <= hs_next;
      sum.payload_fold  <= ps_next;
      sum.udp_zero      <= uz_eff;
      sum.trusted       <= tr_eff;
    end
  end
endmodule

// ===== rtl/core/ipv4rx_queue.sv =====
// Short register FIFO between parser and checker.
// Depends on ipv4rx_pkg.
module ipv4rx_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ipv4rx_pkg::frame_sum_t push_data,
  output logic                   has_room,
  output logic                   not_empty,
  input  logic                   pop,
  output ipv4rx_pkg::frame_sum_t head
);
  import ipv4rx_pkg::*;

  frame_sum_t  slots [QUEUE_DEPTH];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  // Room is kept for one summary already in flight from the front register:
  // the count after this edge must leave one free slot.
  assign has_room  = (count + {1'b0, push}) <= (2'd1 + {1'b0, pop});
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/ipv4rx_back.sv =====
// Back end: two-stage checker producing the verdict word, with L4 error counter.
// Depends on ipv4rx_pkg.
module ipv4rx_back #(
  parameter int ERROR_COUNT_WIDTH = ipv4rx_pkg::ERROR_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            local_address,
  input  logic                   head_valid,
  output logic                   head_pop,
  input  ipv4rx_pkg::frame_sum_t head,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ipv4rx_pkg::out_word_t  out_word
);
  import ipv4rx_pkg::*;

  // Stage 1: header checks and pseudo-header sum.
  logic        s1_valid;
  logic [3:0]  s1_verdict;
  logic        s1_l4_check;     // L4 stage must decide
  logic        s1_l4_fail;      // length failure already known
  logic        s1_need_sum;
  logic [18:0] s1_sum;
  logic [2:0]  s1_class;
  logic [31:0] s1_src;
  logic [5:0]  s1_ihl;
  logic [15:0] s1_l4len;

  logic [ERROR_COUNT_WIDTH-1:0] error_counter;

  logic        adv1, adv2;
  logic [16:0] size;
  logic [5:0]  ihl;
  logic [15:0] l4len;
  logic [3:0]  v;
  logic        chk, lfail, nsum;
  logic [2:0]  pc;
  logic [18:0] psum;
  logic [15:0] fin;
  logic        fail2;

  assign adv2     = s1_valid && (!out_valid || !out_stall);
  assign adv1     = !s1_valid || adv2;
  assign head_pop = head_valid && adv1;

  always_comb begin
    size  = {1'b0, head.size_m1} + 17'd1;
    ihl   = {head.ver_len[3:0], 2'b00};
    l4len = (head.total_length >= {10'd0, ihl}) ?
            head.total_length - {10'd0, ihl} : 16'd0;
    chk = 1'b0;
    if (size < 17'd20)                                   v = V_SHORT;
    else if (head.ver_len[7:4] != 4'd4)                  v = V_VERSION;
    else if (ihl < 6'd20 || {11'd0, ihl} > size)         v = V_HDRLEN;
    else if ({1'b0, head.total_length} > size ||
             head.total_length < {10'd0, ihl})           v = V_TOTLEN;
    else if (fold17(head.header_fold) != 16'hffff)       v = V_HDRSUM;
    else if (head.fragment_word[13:0] != 14'd0)          v = V_FRAGMENT;
    else if (!(head.dest_word == 32'hffffffff || head.dest_word[31:24] == 8'd127 ||
               head.dest_word == 32'd0 || head.dest_word == local_address))
                                                         v = V_NOTOURS;
    else begin
      v   = V_ACCEPT;
      chk = !head.trusted;
    end
    lfail = 1'b0;
    nsum  = 1'b0;
    if (head.protocol == PROTO_UDP) begin
      if (l4len < 16'd8) lfail = 1'b1;
      else nsum = !head.udp_zero;
    end else if (head.protocol == PROTO_TCP) begin
      if (l4len < 16'd20) lfail = 1'b1;
      else nsum = 1'b1;
    end
    case (head.protocol)
      PROTO_ICMP: pc = PC_ICMP;
      PROTO_UDP:  pc = PC_UDP;
      PROTO_TCP:  pc = PC_TCP;
      PROTO_GRE:  pc = PC_GRE;
      default:    pc = PC_OTHER;
    endcase
    psum = {3'd0, head.source_word[31:16]} + {3'd0, head.source_word[15:0]} +
           {3'd0, head.dest_word[31:16]} + {3'd0, head.dest_word[15:0]} +
           {11'd0, head.protocol} + {3'd0, l4len};
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv1) s1_valid <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_verdict  <= v;
      s1_l4_check <= chk;
      s1_l4_fail  <= lfail;
      s1_need_sum <= nsum;
      s1_sum      <= psum + {3'd0, fold17(head.payload_fold)};
      s1_class    <= pc;
      s1_src      <= head.source_word;
      s1_ihl      <= ihl;
      s1_l4len    <= l4len;
    end
  end

  // Stage 2: final fold of the L4 sum, counter update, output register.
  always_comb begin
    fin   = fold17({1'b0, s1_sum[15:0]} + {14'd0, s1_sum[18:16]});
    fail2 = s1_l4_check && (s1_l4_fail || (s1_need_sum && fin != 16'hffff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      error_counter <= '0;
    end else begin
      if (adv2) begin
        out_valid <= 1'b1;
        if (fail2) error_counter <= error_counter + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_word.verdict        <= fail2 ? V_L4SUM : s1_verdict;
      out_word.protocol_class <= s1_class;
      out_word.source_address <= s1_src;
      out_word.header_bytes   <= s1_ihl;
      out_word.payload_bytes  <= s1_l4len;
      if (ERROR_COUNT_WIDTH >= 32)
        out_word.l4_error_count <= 32'(error_counter + ERROR_COUNT_WIDTH'(fail2));
      else
        out_word.l4_error_count <= 32'(error_counter + ERROR_COUNT_WIDTH'(fail2));
    end
  end
endmodule
